// ===== sv/ar2cidr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package ar2cidr_pkg;

    // Fixed widths of the request and result fields.
    localparam int ADDR_FIELD_W = 32;
    localparam int PREFIX_W     = 6;

    // One request: an inclusive address range.
    typedef struct packed {
        logic [ADDR_FIELD_W-1:0] range_low;
        logic [ADDR_FIELD_W-1:0] range_high;
    } range_req_t;

    // One result: an aligned block of the cover.
    typedef struct packed {
        logic [ADDR_FIELD_W-1:0] block_base;
        logic [PREFIX_W-1:0]     prefix_length;
        logic                    last_block;
    } cidr_rsp_t;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_INIT,
        ST_WALK
    } ctrl_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic init;
        logic grow;
        logic shrink;
        logic emit;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic empty;
        logic fit_up;
        logic fit_cur;
        logic last;
        logic out_free;
    } dp_status_t;

endpackage

`default_nettype wire

// ===== sv/address_range_to_cidr_blocks_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel   Ports                       Moves
// request   s_valid, s_ready, s_data    one inclusive range (range_low, range_high)
// result    m_valid, m_ready, m_data    one aligned block (base, prefix, last flag)
//
// A request is loaded, then initialised (an empty range, low above high, ends there
// with no block), then each walk step grows the block exponent, shrinks it, or
// emits one block.
// Results leave through one output register; a stalled result holds the walk.
// A new request is taken once the last block of the previous one is registered.
// Reset is synchronous and active low and clears the controller and the walk state.

module address_range_to_cidr_blocks_unit #(
    parameter int ADDR_WIDTH = 32
) (
    input  wire                     aclk,
    input  wire                     aresetn,
    input  wire                     s_valid,
    output logic                    s_ready,
    input  ar2cidr_pkg::range_req_t s_data,
    output logic                    m_valid,
    input  wire                     m_ready,
    output ar2cidr_pkg::cidr_rsp_t  m_data
);

    ar2cidr_pkg::dp_cmd_t    cmd;
    ar2cidr_pkg::dp_status_t status;

    // Controller.
    ar2cidr_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // Datapath.
    ar2cidr_dp #(
        .ADDR_WIDTH (ADDR_WIDTH)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .cmd     (cmd),
        .status  (status),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // A taken request keeps the unit busy for at least the next cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("request taken while the unit stayed ready");

    // A block is only emitted into a free output register.
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> status.out_free)
        else $error("block emitted over an unread result");

    // Fit is monotone in the exponent: a larger fitting block implies the current one fits.
    assert property (@(posedge aclk) disable iff (!aresetn)
        status.fit_up |-> status.fit_cur)
        else $error("larger block fits but current block does not");

endmodule

`default_nettype wire

// ===== sv/ar2cidr_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ar2cidr_ctrl (
    input  wire                     aclk,
    input  wire                     aresetn,
    input  wire                     s_valid,
    output logic                    s_ready,
    input  ar2cidr_pkg::dp_status_t status,
    output ar2cidr_pkg::dp_cmd_t    cmd
);

    ar2cidr_pkg::ctrl_state_t state_reg;
    ar2cidr_pkg::ctrl_state_t state_next;

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ar2cidr_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state. The walk grows the block exponent while a larger block still fits,
    // emits when the current one is the largest that fits and the output is free, and shrinks otherwise.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ar2cidr_pkg::ST_IDLE: begin
                if (s_valid) begin
                    state_next = ar2cidr_pkg::ST_INIT;
                end
            end
            ar2cidr_pkg::ST_INIT: begin
                if (status.empty) begin
                    state_next = ar2cidr_pkg::ST_IDLE;
                end else begin
                    state_next = ar2cidr_pkg::ST_WALK;
                end
            end
            ar2cidr_pkg::ST_WALK: begin
                if (!status.fit_up && status.fit_cur && status.out_free && status.last) begin
                    state_next = ar2cidr_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = ar2cidr_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs.
    always_comb begin
        s_ready = 1'b0;
        cmd     = '0;
        unique case (state_reg)
            ar2cidr_pkg::ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
            end
            ar2cidr_pkg::ST_INIT: begin
                cmd.init = !status.empty;
            end
            ar2cidr_pkg::ST_WALK: begin
                priority if (status.fit_up) begin
                    cmd.grow = 1'b1;
                end else if (status.fit_cur) begin
                    cmd.emit = status.out_free;
                end else begin
                    cmd.shrink = 1'b1;
                end
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== sv/ar2cidr_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ar2cidr_dp #(
    parameter int ADDR_WIDTH = 32
) (
    input  wire                     aclk,
    input  wire                     aresetn,
    input  ar2cidr_pkg::range_req_t s_data,
    input  ar2cidr_pkg::dp_cmd_t    cmd,
    output ar2cidr_pkg::dp_status_t status,
    output logic                    m_valid,
    input  wire                     m_ready,
    output ar2cidr_pkg::cidr_rsp_t  m_data
);

    localparam int KW = $clog2(ADDR_WIDTH + 1);
    localparam int PW = ar2cidr_pkg::PREFIX_W;
    localparam int BW = ar2cidr_pkg::ADDR_FIELD_W;
    localparam logic [KW-1:0] K_MAX   = KW'(ADDR_WIDTH);
    localparam logic [PW-1:0] PFX_MAX = PW'(ADDR_WIDTH);

    logic [ADDR_WIDTH-1:0] lo_reg, lo_next;
    logic [ADDR_WIDTH:0]   cnt_reg, cnt_next;
    logic [KW-1:0]         k_reg, k_next;
    logic                  m_valid_reg, m_valid_next;
    ar2cidr_pkg::cidr_rsp_t m_data_reg, m_data_next;

    logic [ADDR_WIDTH-1:0] lo_in, hi_in, lo_plus;
    logic [ADDR_WIDTH:0]   diff, mask_cur, mask_up, pow2, cnt_less;
    logic [63:0]           base_wide;

    // Bring the request fields to the address width.
    assign lo_in = ADDR_WIDTH'(s_data.range_low);
    assign hi_in = ADDR_WIDTH'(s_data.range_high);
    assign diff  = {1'b0, hi_in} - {1'b0, lo_in};

    // Masks for the current block exponent k: ones below k, ones below k+1, and 2^k.
    assign mask_cur = ~({(ADDR_WIDTH + 1){1'b1}} << k_reg);
    assign mask_up  = {mask_cur[ADDR_WIDTH-1:0], 1'b1};
    assign pow2     = mask_up & ~mask_cur;

    // Advance past the current block.
    assign lo_plus  = lo_reg + pow2[ADDR_WIDTH-1:0];
    assign cnt_less = cnt_reg - pow2;

    // A block of size 2^k fits when the low address is aligned to it and the
    // remaining count is at least 2^k. During init the count register holds the
    // signed difference, whose top bit marks an empty range.
    always_comb begin
        status.empty    = cnt_reg[ADDR_WIDTH];
        status.fit_cur  = !(|(lo_reg & mask_cur[ADDR_WIDTH-1:0]))
                          && (|(cnt_reg & ~mask_cur));
        status.fit_up   = (k_reg != K_MAX)
                          && !(|(lo_reg & mask_up[ADDR_WIDTH-1:0]))
                          && (|(cnt_reg & ~mask_up));
        status.last     = (cnt_less == '0);
        status.out_free = !m_valid_reg || m_ready;
    end

    // Next values of the walk registers.
    always_comb begin
        lo_next  = lo_reg;
        cnt_next = cnt_reg;
        k_next   = k_reg;
        priority if (cmd.load) begin
            lo_next  = lo_in;
            cnt_next = diff;
        end else if (cmd.init) begin
            cnt_next = cnt_reg + (ADDR_WIDTH + 1)'(1);
            k_next   = K_MAX;
        end else if (cmd.grow) begin
            k_next = k_reg + KW'(1);
        end else if (cmd.shrink) begin
            k_next = k_reg - KW'(1);
        end else if (cmd.emit) begin
            lo_next  = lo_plus;
            cnt_next = cnt_less;
        end
    end

    // Output register: loaded on emit, emptied when the result is taken.
    assign base_wide = 64'(lo_reg);

    always_comb begin
        m_data_next  = m_data_reg;
        m_valid_next = m_valid_reg;
        if (cmd.emit) begin
            m_data_next.block_base    = base_wide[BW-1:0];
            m_data_next.prefix_length = PFX_MAX - PW'(k_reg);
            m_data_next.last_block    = status.last;
            m_valid_next              = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lo_reg      <= '0;
            cnt_reg     <= '0;
            k_reg       <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            lo_reg      <= lo_next;
            cnt_reg     <= cnt_next;
            k_reg       <= k_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

`default_nettype wire
